// File: sv/cpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the contiguous partition allocator.
package cpa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FILL,
    ST_FREE,
    ST_RES
  } state_t;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_BEYOND    = 2'd3;

  localparam logic REG_FIT_MODE   = 1'b0;
  localparam logic REG_MEMORY_TOP = 1'b1;

endpackage

// File: sv/cpa_cell.sv
`timescale 1ns / 1ps
// One table cell: holds one partition and takes its neighbor's on shift.
module cpa_cell import cpa_pkg::*; #(
  parameter int AW = 32
) (
  input  logic          clk,
  input  logic          shift,
  input  logic [AW-1:0] nb_begin,
  input  logic [AW-1:0] nb_end,
  output logic [AW-1:0] cell_begin,
  output logic [AW-1:0] cell_end
);

  logic [AW-1:0] begin_r;
  logic [AW-1:0] end_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      begin_r <= nb_begin;
      end_r   <= nb_end;
    end
  end

  assign cell_begin = begin_r;
  assign cell_end   = end_r;

endmodule

// File: sv/contiguous_partition_allocator.sv
`timescale 1ns / 1ps
// Contiguous partition allocator: top level with sequencer and cell ring.
//
// Usage: an input word (in_operation, in_request_size, in_free_begin) is
// taken when in_valid is high and in_stall is low. Each word yields exactly
// one result word on the out_ channel (status, begin/end address, count).
// The partition table sits in a ring of MAX_PARTITIONS cells that rotates
// one place per cycle while a scan, rebuild or free runs, so the entry
// under inspection always sits in cell 0. A free takes one full rotation.
// An allocate takes a scan rotation, a decision step and, when it is
// placed, a rebuild rotation that inserts the new entry. A full table is
// refused without a scan. One word is in work at a time; the next is
// taken as soon as the result has moved into the output register, even
// while the receiver still stalls that result.
// Reset (rst_n low at a clock edge) empties the table, clears the next-fit
// rover, sets fit_mode to first fit and memory_top to all ones. Cell
// contents are not cleared; only entries below the count are ever read.
// A stalled result holds on the out_ ports until taken. The APB port
// (fit_mode at 0x0, memory_top at 0x4) is to be written only while idle;
// the block itself does not enforce it.
module contiguous_partition_allocator import cpa_pkg::*; #(
  parameter int MAX_PARTITIONS = 64,
  parameter int ADDR_WIDTH     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_free_begin,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_begin_address,
  output logic [31:0] out_end_address,
  output logic [6:0]  out_partition_count,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N   = MAX_PARTITIONS;
  localparam int AW  = ADDR_WIDTH;
  localparam int IW  = $clog2(N);
  localparam int CNW = $clog2(N + 1);
  localparam int CW  = ((AW > 32) ? AW : 32) + 1;   // compare width

  // ---------------- configuration registers
  logic [1:0]  fit_mode_r;
  logic [31:0] memory_top_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_MEMORY_TOP) ? memory_top_r : {30'd0, fit_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= FIT_FIRST;
      memory_top_r <= '1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIT_MODE) fit_mode_r <= pwdata[1:0];
      else                          memory_top_r <= pwdata;
    end
  end

  // ---------------- cell ring
  logic [AW-1:0] c_begin [N];
  logic [AW-1:0] c_end   [N];
  logic [AW-1:0] tail_begin, tail_end;
  logic          shift;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [AW-1:0] nb_b, nb_e;
    if (i == N - 1) begin : g_tail
      assign nb_b = tail_begin;
      assign nb_e = tail_end;
    end else begin : g_mid
      assign nb_b = c_begin[i+1];
      assign nb_e = c_end[i+1];
    end
    cpa_cell #(.AW(AW)) u_cell (
      .clk        (clk),
      .shift      (shift),
      .nb_begin   (nb_b),
      .nb_end     (nb_e),
      .cell_begin (c_begin[i]),
      .cell_end   (c_end[i])
    );
  end

  // ---------------- sequencer state
  state_t         state_r, state_nxt;
  logic [IW-1:0]  step_r;
  logic [CNW-1:0] count_r;
  logic [CNW-1:0] rover_r;
  logic [31:0]    size_r;
  logic [AW-1:0]  fb_r;
  logic [AW-1:0]  prev_end_r, last_end_r;
  logic           found_r, lo_found_r;
  logic [IW-1:0]  pos_r, lo_pos_r;
  logic [AW-1:0]  start_r, lo_start_r, best_r;
  logic [AW-1:0]  new_end_r;
  logic [AW-1:0]  carry_b_r, carry_e_r;
  logic [1:0]     res_status_r;
  logic [AW-1:0]  res_begin_r, res_end_r;
  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [31:0]    out_begin_r, out_end_r;
  logic [6:0]     out_count_r;

  logic last_step, in_acc, out_free;
  assign last_step = (step_r == IW'(N - 1));
  assign in_acc    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------- per-step evaluation of the head cell
  logic [CW-1:0]  size_ext, limit_ext, hole_ext;
  logic [AW-1:0]  hole, cand_start;
  logic           entry_ok, fits, best_upd;
  logic [CNW-1:0] step_ext, next_first;
  logic [CW-1:0]  mask_ext, top_ext;

  assign size_ext   = CW'(size_r);
  assign mask_ext   = CW'({AW{1'b1}});
  assign top_ext    = CW'(memory_top_r);
  assign limit_ext  = (top_ext < mask_ext) ? top_ext : mask_ext;
  assign step_ext   = CNW'(step_r);
  assign entry_ok   = step_ext < count_r;
  assign hole       = (step_r == '0) ? c_begin[0] : (c_begin[0] - prev_end_r - AW'(1));
  assign hole_ext   = CW'(hole);
  assign cand_start = (step_r == '0) ? '0 : (prev_end_r + AW'(1));
  assign fits       = entry_ok && (hole_ext >= size_ext);
  assign next_first = (rover_r < count_r) ? rover_r : '0;
  assign best_upd   = !found_r || ((fit_mode_r == FIT_BEST) && (hole < best_r)) ||
                      ((fit_mode_r == FIT_WORST) && (hole > best_r));

  // free: match on the head entry
  logic hit;
  assign hit = entry_ok && !found_r && (c_begin[0] == fb_r);

  // ---------------- placement decision
  logic           dec_found, dec_beyond;
  logic [IW-1:0]  dec_pos;
  logic [AW-1:0]  dec_start;
  logic [CW-1:0]  dec_start_ext;

  always_comb begin
    dec_found  = found_r || ((fit_mode_r == FIT_NEXT) && lo_found_r);
    dec_pos    = found_r ? pos_r : lo_pos_r;
    dec_start  = found_r ? start_r : lo_start_r;
    dec_beyond = 1'b0;
    if (!dec_found) begin
      dec_pos = IW'(count_r);
      if (count_r == '0) begin
        dec_start = '0;
      end else if (CW'(last_end_r) >= limit_ext) begin
        dec_beyond = 1'b1;
        dec_start  = '0;
      end else begin
        dec_start = last_end_r + AW'(1);
      end
    end
    dec_start_ext = CW'(dec_start);
    if ((dec_start_ext > limit_ext) ||
        ((size_ext - CW'(1)) > (limit_ext - dec_start_ext))) begin
      dec_beyond = 1'b1;
    end
  end

  // ---------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_FREE)           state_nxt = ST_FREE;
          else if (count_r >= CNW'(N))           state_nxt = ST_RES;
          else                                   state_nxt = ST_SCAN;
        end
      end
      ST_SCAN:   if (last_step) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = dec_beyond ? ST_RES : ST_FILL;
      ST_FILL:   if (last_step) state_nxt = ST_RES;
      ST_FREE:   if (last_step) state_nxt = ST_RES;
      ST_RES:    if (out_free)  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    shift      = 1'b0;
    tail_begin = c_begin[0];
    tail_end   = c_end[0];
    case (state_r)
      ST_SCAN: begin
        shift = 1'b1;                       // plain rotation
      end
      ST_FILL: begin
        shift = 1'b1;
        if (step_r == pos_r) begin          // drop the new entry in
          tail_begin = start_r;
          tail_end   = new_end_r;
        end else if (step_r > pos_r) begin  // then run one place late
          tail_begin = carry_b_r;
          tail_end   = carry_e_r;
        end
      end
      ST_FREE: begin
        shift = 1'b1;
        if (hit || found_r) begin           // skip the freed entry
          tail_begin = c_begin[1];
          tail_end   = c_end[1];
        end
      end
      default: begin
        shift = 1'b0;
      end
    endcase
  end

  // ---------------- sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      rover_r     <= '0;
      found_r     <= 1'b0;
      lo_found_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load a new result word, or drop the one just taken
      if ((state_r == ST_RES) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                 out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          step_r     <= '0;
          found_r    <= 1'b0;
          lo_found_r <= 1'b0;
          if (in_acc) begin
            size_r       <= (in_request_size == '0) ? 32'd1 : in_request_size;
            fb_r         <= AW'(in_free_begin);
            res_status_r <= STS_FULL;
            res_begin_r  <= '0;
            res_end_r    <= '0;
          end
        end
        ST_SCAN: begin
          step_r     <= step_r + IW'(1);
          prev_end_r <= c_end[0];
          if (step_ext == count_r - CNW'(1)) last_end_r <= c_end[0];
          if (fits) begin
            case (fit_mode_r)
              FIT_FIRST: begin
                if (!found_r) begin
                  found_r <= 1'b1;
                  pos_r   <= step_r;
                  start_r <= cand_start;
                end
              end
              FIT_NEXT: begin
                if (step_ext >= next_first) begin
                  if (!found_r) begin
                    found_r <= 1'b1;
                    pos_r   <= step_r;
                    start_r <= cand_start;
                  end
                end else if (!lo_found_r) begin
                  lo_found_r <= 1'b1;
                  lo_pos_r   <= step_r;
                  lo_start_r <= cand_start;
                end
              end
              default: begin
                if (best_upd) begin
                  found_r <= 1'b1;
                  pos_r   <= step_r;
                  start_r <= cand_start;
                  best_r  <= hole;
                end
              end
            endcase
          end
        end
        ST_DECIDE: begin
          step_r    <= '0;
          pos_r     <= dec_pos;
          start_r   <= dec_start;
          new_end_r <= AW'(dec_start_ext + size_ext - CW'(1));
          if (dec_beyond) begin
            res_status_r <= STS_BEYOND;
            res_begin_r  <= '0;
            res_end_r    <= '0;
          end
        end
        ST_FILL: begin
          step_r    <= step_r + IW'(1);
          carry_b_r <= c_begin[0];
          carry_e_r <= c_end[0];
          if (last_step) begin
            count_r      <= count_r + CNW'(1);
            res_status_r <= STS_OK;
            res_begin_r  <= start_r;
            res_end_r    <= new_end_r;
            if (fit_mode_r == FIT_NEXT)           rover_r <= CNW'(pos_r) + CNW'(1);
            else if (CNW'(pos_r) < rover_r)       rover_r <= rover_r + CNW'(1);
          end
        end
        ST_FREE: begin
          step_r <= step_r + IW'(1);
          if (hit) begin
            found_r     <= 1'b1;
            pos_r       <= step_r;
            res_begin_r <= c_begin[0];
            res_end_r   <= c_end[0];
          end
          if (last_step) begin
            if (found_r || hit) begin
              res_status_r <= STS_OK;
              count_r      <= count_r - CNW'(1);
              if ((hit ? step_ext : CNW'(pos_r)) < rover_r) rover_r <= rover_r - CNW'(1);
            end else begin
              res_status_r <= STS_NOT_FOUND;
            end
          end
        end
        default: begin
          step_r <= '0;
        end
      endcase
    end
  end

  // result word into the output register; held while stalled
  logic [CW-1:0] res_b_ext, res_e_ext;
  assign res_b_ext = CW'(res_begin_r);
  assign res_e_ext = CW'(res_end_r);

  always_ff @(posedge clk) begin
    if ((state_r == ST_RES) && out_free) begin
      out_status_r <= res_status_r;
      out_begin_r  <= res_b_ext[31:0];
      out_end_r    <= res_e_ext[31:0];
      out_count_r  <= 7'(count_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_begin_address   = out_begin_r;
  assign out_end_address     = out_end_r;
  assign out_partition_count = out_count_r;

endmodule

// File: tb/tb_contiguous_partition_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench of the contiguous partition allocator.
module tb_contiguous_partition_allocator;
  import cpa_pkg::*;

  localparam int NPART = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = OP_ALLOC;
  logic [31:0] in_request_size = 32'd1;
  logic [31:0] in_free_begin = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_begin_address;
  logic [31:0] out_end_address;
  logic [6:0]  out_partition_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  contiguous_partition_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_request_size(in_request_size), .in_free_begin(in_free_begin),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_begin_address(out_begin_address), .out_end_address(out_end_address),
    .out_partition_count(out_partition_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic        op;
    logic [31:0] size;
    logic [31:0] fbegin;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] b;
    logic [31:0] e;
    logic [6:0]  count;
  } outcome_t;

  // Shadow copy of the partition table and registers.
  logic [31:0] tbl_begin [NPART];
  logic [31:0] tbl_end   [NPART];
  int          tbl_count;
  int          rover;
  logic [1:0]  shadow_mode;
  logic [31:0] shadow_top;

  request_t pending_words[$];
  outcome_t expected_outcomes[$];
  int       mismatches;
  int       results_seen;
  int       sent_count;
  bit       send_idle_ok;   // random gaps on the input side
  bit       recv_idle_ok;   // random stalls on the output side
  bit       hold_receiver;  // long receiver hold-off request
  int       hold_cycles;

  function automatic logic [32:0] gap_below(int k);
    if (k == 0) return {1'b0, tbl_begin[0]};
    return {1'b0, tbl_begin[k]} - {1'b0, tbl_end[k-1]} - 33'd1;
  endfunction

  // Compute the outcome of one word and advance the shadow table.
  function automatic outcome_t place_or_free(request_t w);
    outcome_t    r;
    logic [32:0] sz, h, bestsz, start;
    int          pos, k, first;
    bit          found;
    r = '0;
    pos = 0;
    found = 0;
    bestsz = '0;
    if (w.op == OP_FREE) begin
      r.status = STS_NOT_FOUND;
      for (k = 0; k < tbl_count; k++) begin
        if (!found && tbl_begin[k] == w.fbegin) begin
          found = 1;
          pos = k;
        end
      end
      if (found) begin
        r.status = STS_OK;
        r.b = tbl_begin[pos];
        r.e = tbl_end[pos];
        for (k = pos; k + 1 < tbl_count; k++) begin
          tbl_begin[k] = tbl_begin[k+1];
          tbl_end[k] = tbl_end[k+1];
        end
        tbl_count--;
        if (pos < rover) rover--;
      end
      r.count = tbl_count[6:0];
      return r;
    end
    sz = (w.size == 0) ? 33'd1 : {1'b0, w.size};
    r.count = tbl_count[6:0];
    if (tbl_count >= NPART) begin
      r.status = STS_FULL;
      return r;
    end
    if (shadow_mode == FIT_NEXT) begin
      first = (rover < tbl_count) ? rover : 0;
      for (int t = 0; t < tbl_count; t++) begin
        k = first + t;
        if (k >= tbl_count) k -= tbl_count;
        if (!found && gap_below(k) >= sz) begin
          pos = k;
          found = 1;
        end
      end
    end else begin
      for (k = 0; k < tbl_count; k++) begin
        h = gap_below(k);
        if (h >= sz && !(shadow_mode == FIT_FIRST && found)) begin
          if (!found || (shadow_mode == FIT_BEST && h < bestsz) ||
              (shadow_mode == FIT_WORST && h > bestsz)) begin
            pos = k;
            bestsz = h;
            found = 1;
          end
        end
      end
    end
    if (found) begin
      start = (pos == 0) ? 33'd0 : {1'b0, tbl_end[pos-1]} + 33'd1;
    end else begin
      pos = tbl_count;
      start = (tbl_count == 0) ? 33'd0 : {1'b0, tbl_end[tbl_count-1]} + 33'd1;
    end
    if (start > {1'b0, shadow_top} || sz - 33'd1 > {1'b0, shadow_top} - start) begin
      r.status = STS_BEYOND;
      return r;
    end
    for (k = tbl_count; k > pos; k--) begin
      tbl_begin[k] = tbl_begin[k-1];
      tbl_end[k] = tbl_end[k-1];
    end
    tbl_begin[pos] = start[31:0];
    tbl_end[pos] = start[31:0] + sz[31:0] - 32'd1;
    tbl_count++;
    if (shadow_mode == FIT_NEXT) rover = pos + 1;
    else if (pos < rover) rover++;
    r.status = STS_OK;
    r.b = tbl_begin[pos];
    r.e = tbl_end[pos];
    r.count = tbl_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want,
             results_seen);
    mismatches++;
  endtask

  // Driver: present the head of the queue; predict on acceptance.
  int send_gap;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(place_or_free(pending_words.pop_front()));
        sent_count++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        if (!(in_valid && in_stall)) in_valid <= 1'b0;
      end else if (in_valid && in_stall) begin
        // hold the stalled word as it is
      end else if (pending_words.size() > (in_valid && !in_stall ? 0 : 0) &&
                   pending_words.size() > 0) begin
        if (send_idle_ok && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 16);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_operation <= pending_words[0].op;
          in_request_size <= pending_words[0].size;
          in_free_begin <= pending_words[0].fbegin;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  int recv_gap;
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected word", 32'd0, 32'd0);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_begin_address !== want.b) report_mismatch("begin", out_begin_address, want.b);
          if (out_end_address !== want.e) report_mismatch("end", out_end_address, want.e);
          if (out_partition_count !== want.count)
            report_mismatch("count", 32'(out_partition_count), 32'(want.count));
        end
      end
      // Stall control: a long hold-off wins over random bursts.
      if (hold_receiver) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles + 1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (recv_idle_ok && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_FIT_MODE) shadow_mode = value[1:0];
    else shadow_top = value;
  endtask

  // Block until every word is sent and answered, then let the engine settle.
  task automatic drain;
    while (pending_words.size() != 0 || expected_outcomes.size() != 0 || in_valid)
      @(posedge clk);
    repeat (2 * NPART + 10) @(posedge clk);
  endtask

  task automatic push_word(input logic op, input logic [31:0] size,
                           input logic [31:0] fb);
    request_t w;
    w.op = op; w.size = size; w.fbegin = fb;
    pending_words.push_back(w);
  endtask

  // Random word: mostly small allocations and frees of live partitions.
  task automatic push_random;
    int sel;
    logic [31:0] fb;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      push_word(OP_ALLOC, (sel < 3) ? $urandom : $urandom_range(0, 40), $urandom);
    end else begin
      // pick a begin address likely present once the queue drains
      fb = (sel < 90 && tbl_count > 0) ? tbl_begin[$urandom_range(0, tbl_count - 1)]
                                       : $urandom;
      push_word(OP_FREE, $urandom, fb);
    end
  endtask

  initial begin
    logic [31:0] tops [4];
    mismatches = 0; results_seen = 0; sent_count = 0;
    send_idle_ok = 0; recv_idle_ok = 0; hold_receiver = 0; hold_cycles = 0;
    send_gap = 0; recv_gap = 0;
    tbl_count = 0; rover = 0; shadow_mode = FIT_FIRST; shadow_top = 32'hFFFF_FFFF;
    for (int k = 0; k < NPART; k++) begin
      tbl_begin[k] = '0; tbl_end[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: free on empty table, extremes, holes, beyond top, zero size.
    push_word(OP_FREE, 32'd0, 32'd0);
    push_word(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    push_word(OP_ALLOC, 32'd10, 32'd0);
    push_word(OP_ALLOC, 32'd5, 32'd0);
    push_word(OP_ALLOC, 32'd20, 32'd0);
    push_word(OP_FREE, 32'd0, 32'd1);
    push_word(OP_FREE, 32'd0, 32'd0);
    push_word(OP_ALLOC, 32'd1, 32'd0);
    push_word(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    push_word(OP_FREE, 32'd0, 32'd12345);
    push_word(OP_ALLOC, 32'h8000_0000, 32'd0);
    push_word(OP_ALLOC, 32'h7FFF_0000, 32'd0);
    drain();
    for (int m = 0; m < 4; m++) begin
      cfg_write(REG_FIT_MODE, m);
      push_word(OP_ALLOC, 32'd3, 32'd0);
      push_word(OP_FREE, 32'd0, tbl_count > 1 ? tbl_begin[1] : 32'd0);
      push_word(OP_ALLOC, 32'd2, 32'd0);
      drain();
    end
    // Empty the table, allocate under a top of zero, then fill to full.
    while (tbl_count > 0) begin
      push_word(OP_FREE, 32'd0, tbl_begin[0]);
      drain();
    end
    cfg_write(REG_MEMORY_TOP, 32'd0);
    push_word(OP_ALLOC, 32'd1, 32'd0);
    push_word(OP_ALLOC, 32'd1, 32'd0);
    drain();
    cfg_write(REG_MEMORY_TOP, 32'hFFFF_FFFF);
    for (int k = 0; k < NPART + 2; k++) push_word(OP_ALLOC, 32'd1, 32'd0);
    // Long receiver hold-off while the sender keeps offering.
    hold_receiver = 1;
    while (hold_cycles < 600) @(posedge clk);
    hold_receiver = 0;
    drain();

    // Random phases across modes and tops.
    send_idle_ok = 1; recv_idle_ok = 1;
    tops[0] = 32'hFFFF_FFFF; tops[1] = 32'd300; tops[2] = 32'd0; tops[3] = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_FIT_MODE, ph % 4);
      cfg_write(REG_MEMORY_TOP, tops[(ph / 2) % 4] | (ph == 3 ? 32'd0 : 32'd0));
      if (ph == 7) begin
        send_idle_ok = 0; recv_idle_ok = 0;
      end
      for (int n = 0; n < 60; n++) begin
        push_random();
        // sender pauses until the queue is answered now and then
        if (n % 15 == 14) drain();
      end
      drain();
    end
    cfg_write(REG_MEMORY_TOP, 32'hFFFF_FFFF);
    drain();

    $display("covered %0d words, %0d results, all fit modes and memory tops",
             sent_count, results_seen);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("PASS contiguous_partition_allocator");
    end else begin
      $display("FAIL contiguous_partition_allocator");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL contiguous_partition_allocator");
    $finish;
  end

endmodule
